// ===== src/ptpcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptpcd_pkg
// shared types and constants for the ptp pi clock discipline core
// ----------------------------------------------------------------------------
package ptpcd_pkg;

    // field widths
    localparam int TIME_W   = 64;
    localparam int CORR_W   = 40;
    localparam int GAIN_W   = 32;
    localparam int THR_W    = 32;
    localparam int LCNT_W   = 16;
    localparam int QUAL_W   = 7;
    localparam int INTEG_W  = 62;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // default fractional bits of the correction
    localparam int CORR_FRAC_BITS_DEF = 40;
    localparam int PROP_SCALE_BITS    = 56;
    localparam int INT_SCALE_BITS     = 72;

    // serial multiplier: signed a times unsigned b
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 34;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // serial divider for lock quality
    localparam int DIV_N_W   = 23;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // loop constants
    localparam logic [TIME_W-1:0]         DT_LIMIT   = 64'd10000000000;
    localparam logic signed [INTEG_W-1:0] ACC_LIMIT  = 62'sd1000000000000000000;
    localparam logic signed [48:0]        NEW_LIMIT  = 49'sd140737488355328;
    localparam logic [MUL_B_W-1:0]        SMOOTH_NUM = 34'd6554;
    localparam int                        SMOOTH_SH  = 16;
    localparam logic [QUAL_W-1:0]         QUAL_FULL  = 7'd100;

    // register reset values
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST = 32'd640000000;
    localparam logic [GAIN_W-1:0]        INT_GAIN_RST  = 32'd186000;
    localparam logic signed [CORR_W-1:0] CORR_MIN_RST  = -40'sd109951163;
    localparam logic signed [CORR_W-1:0] CORR_MAX_RST  = 40'sd109951163;
    localparam logic [THR_W-1:0]         LOCK_THR_RST  = 32'd1000;
    localparam logic [LCNT_W-1:0]        LOCK_MAX_RST  = 16'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MAX  = 3'd5;

    typedef enum logic [1:0] {
        STATUS_PRIMED   = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_UPDATED  = 2'd2,
        STATUS_CLEARED  = 2'd3
    } status_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage
`default_nettype wire

// ===== src/ptpcd_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptpcd_mul
// bit-serial shift-add multiplier, signed a by unsigned b, one b bit per cycle
// ----------------------------------------------------------------------------
module ptpcd_mul
    import ptpcd_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0]        b,
    output unit_sts_t                      sts,
    output logic signed [MUL_P_W-1:0]      product
);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W:0]   hi_reg;
    logic [MUL_B_W-1:0]        lo_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [MUL_A_W:0]   sum;

    // add a when the current multiplier bit is set
    assign sum = hi_reg + (lo_reg[0] ? {a_reg[MUL_A_W-1], a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                hi_reg   <= '0;
                lo_reg   <= b;
                cnt_reg  <= MUL_CNT_W'(MUL_B_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                hi_reg  <= {sum[MUL_A_W], sum[MUL_A_W:1]};
                lo_reg  <= {sum[0], lo_reg[MUL_B_W-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign product  = $signed(MUL_P_W'({hi_reg, lo_reg}));
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule
`default_nettype wire

// ===== src/ptpcd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptpcd_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptpcd_div
    import ptpcd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] num,
    input  wire logic [DIV_D_W-1:0] den,
    output unit_sts_t               sts,
    output logic [DIV_N_W-1:0]      quot
);

    logic [DIV_N_W-1:0]   q_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    assign shifted = {rem_reg, q_reg[DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
                q_reg   <= {q_reg[DIV_N_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot     = q_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule
`default_nettype wire

// ===== src/ptp_pi_clock_discipline_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_pi_clock_discipline_core
// type-2 proportional-plus-integral loop filter for ptp clock discipline
// ----------------------------------------------------------------------------
// Each input item carries a local and a remote timestamp in ns, or a clear
// action. The first pair with a nonzero local time primes the loop; later
// pairs form the phase error e = remote - local and the step dt, integrate
// e*dt (saturating at +-1e18 ns^2), build a new correction from the
// proportional and integral terms, smooth the output correction toward it by
// about 0.1 and clamp it to [corr_min, corr_max]. A lock counter rises by one
// while |e| is under the threshold and falls by two otherwise. Every item
// gives exactly one result item. One item is worked on at a time: a loop
// update makes four passes through the shared 34-bit bit-serial multiplier
// and one 23-bit pass of the serial divider that forms the lock quality;
// prime, reject and clear use the divider only. A stalled output delays
// the hand-over. A finished result waits in the output register while the
// next item is taken. The user must write the registers through
// cfg_we/cfg_index/cfg_wdata only while no item is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module ptp_pi_clock_discipline_core
    import ptpcd_pkg::*;
#(
    parameter int CORR_FRAC_BITS = CORR_FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic [TIME_W-1:0]     local_time,
    input  wire logic [TIME_W-1:0]     remote_time,
    // result items
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 status,
    output logic signed [CORR_W-1:0]   freq_correction,
    output logic signed [TIME_W-1:0]   phase_error_ns,
    output logic [QUAL_W-1:0]          lock_quality
);

    // shift amounts of the two loop terms
    localparam int SH_P  = PROP_SCALE_BITS - CORR_FRAC_BITS;
    localparam int SH_I  = INT_SCALE_BITS - CORR_FRAC_BITS;
    localparam int NC_W  = 49;   // saturated new correction, +-2^47
    localparam int D_W   = 50;   // new minus current correction
    localparam int C_W   = 50;   // smoothed correction before clamp
    localparam int ACC_W = INTEG_W + 3;

    localparam logic signed [MUL_P_W-1:0] SUM_POS = MUL_P_W'(NEW_LIMIT);
    localparam logic signed [MUL_P_W-1:0] SUM_NEG = -SUM_POS;
    localparam logic signed [ACC_W-1:0]   ACC_POS = ACC_W'(ACC_LIMIT);
    localparam logic signed [ACC_W-1:0]   ACC_NEG = -ACC_POS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_ED,
        S_MUL_P,
        S_MUL_I,
        S_SAT,
        S_DIFF,
        S_MUL_S,
        S_CLAMP,
        S_QSTART,
        S_QUAL,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]        prop_gain_reg;
    logic [GAIN_W-1:0]        int_gain_reg;
    logic signed [CORR_W-1:0] corr_min_reg;
    logic signed [CORR_W-1:0] corr_max_reg;
    logic [THR_W-1:0]         lock_thr_reg;
    logic [LCNT_W-1:0]        lock_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg <= PROP_GAIN_RST;
            int_gain_reg  <= INT_GAIN_RST;
            corr_min_reg  <= CORR_MIN_RST;
            corr_max_reg  <= CORR_MAX_RST;
            lock_thr_reg  <= LOCK_THR_RST;
            lock_max_reg  <= LOCK_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN: prop_gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_INT_GAIN:  int_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_CORR_MIN:  corr_min_reg  <= $signed(cfg_wdata[CORR_W-1:0]);
                CFG_CORR_MAX:  corr_max_reg  <= $signed(cfg_wdata[CORR_W-1:0]);
                CFG_LOCK_THR:  lock_thr_reg  <= cfg_wdata[THR_W-1:0];
                CFG_LOCK_MAX:  lock_max_reg  <= cfg_wdata[LCNT_W-1:0];
                default:       ;   // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // loop state, item registers and working registers
    // ------------------------------------------------------------------
    state_t                    state_reg;
    logic                      action_reg;
    logic [TIME_W-1:0]         local_reg;
    logic [TIME_W-1:0]         remote_reg;
    logic [TIME_W-1:0]         prev_local_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [CORR_W-1:0]  corr_reg;
    logic [LCNT_W-1:0]         lcnt_reg;
    logic signed [TIME_W-1:0]  prev_phase_reg;
    logic signed [TIME_W-1:0]  e_reg;
    logic signed [MUL_P_W-1:0] term_reg;
    logic signed [MUL_P_W-1:0] sum_reg;
    logic signed [NC_W-1:0]    nc_reg;
    logic signed [C_W-1:0]     c_reg;
    status_t                   status_reg;

    // shared arithmetic units
    logic                      mul_start_reg;
    logic signed [MUL_A_W-1:0] mul_a_reg;
    logic [MUL_B_W-1:0]        mul_b_reg;
    unit_sts_t                 mul_sts;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start_reg;
    logic [DIV_N_W-1:0]        div_num_reg;
    unit_sts_t                 div_sts;
    logic [DIV_N_W-1:0]        div_q;

    // result register
    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic signed [CORR_W-1:0]  out_corr_reg;
    logic signed [TIME_W-1:0]  out_phase_reg;
    logic [QUAL_W-1:0]         out_qual_reg;
    logic [QUAL_W-1:0]         qual_reg;

    ptpcd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .sts     (mul_sts),
        .product (mul_p)
    );

    ptpcd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (lock_max_reg),
        .sts   (div_sts),
        .quot  (div_q)
    );

    // ------------------------------------------------------------------
    // datapath terms
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]         dt_full;
    logic [TIME_W-1:0]         e_full;
    logic                      step_bad;
    logic                      prod_fits;
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [INTEG_W-1:0] integ_new;
    logic [TIME_W-1:0]         mag;
    logic                      below_thr;
    logic [LCNT_W-1:0]         lcnt_new;
    logic signed [D_W-1:0]     diff;
    logic signed [C_W-1:0]     c_min;
    logic signed [C_W-1:0]     c_max;
    logic signed [C_W-1:0]     c_lo;
    logic signed [C_W-1:0]     c_fin;
    logic [DIV_N_W-1:0]        lcnt_x100;
    logic signed [NC_W-1:0]    nc_sat;

    assign dt_full  = local_reg - prev_local_reg;
    assign e_full   = remote_reg - local_reg;
    // time going backwards wraps into a huge step
    assign step_bad = (dt_full == '0) || (dt_full > DT_LIMIT);

    // e*dt beyond 64 bits lies far past the integrator limit
    assign prod_fits = (&mul_p[MUL_P_W-1:TIME_W-1]) || !(|mul_p[MUL_P_W-1:TIME_W-1]);
    assign acc_sum   = ACC_W'(integ_reg) + ACC_W'($signed(mul_p[TIME_W-1:0]));

    always_comb
    begin
        if (!prod_fits)
            integ_new = e_reg[TIME_W-1] ? -ACC_LIMIT : ACC_LIMIT;
        else if (acc_sum > ACC_POS)
            integ_new = ACC_LIMIT;
        else if (acc_sum < ACC_NEG)
            integ_new = -ACC_LIMIT;
        else
            integ_new = acc_sum[INTEG_W-1:0];
    end

    // lock counter
    assign mag       = e_reg[TIME_W-1] ? (~e_reg + TIME_W'(1)) : e_reg;
    assign below_thr = (mag[TIME_W-1:THR_W] == '0) && (mag[THR_W-1:0] < lock_thr_reg);

    always_comb
    begin
        if (below_thr)
            lcnt_new = (lcnt_reg < lock_max_reg) ? lcnt_reg + 1'b1 : lcnt_reg;
        else
            lcnt_new = (lcnt_reg >= LCNT_W'(2)) ? lcnt_reg - LCNT_W'(2) : '0;
    end

    // new correction saturated to +-2^47
    always_comb
    begin
        if (sum_reg > SUM_POS)
            nc_sat = NEW_LIMIT;
        else if (sum_reg < SUM_NEG)
            nc_sat = -NEW_LIMIT;
        else
            nc_sat = sum_reg[NC_W-1:0];
    end

    assign diff = D_W'(nc_reg) - D_W'(corr_reg);

    // clamp raises to corr_min first, then lowers to corr_max
    assign c_min = C_W'(corr_min_reg);
    assign c_max = C_W'(corr_max_reg);
    assign c_lo  = (c_reg < c_min) ? c_min : c_reg;
    assign c_fin = (c_lo > c_max) ? c_max : c_lo;

    // lock_count * 100 as 64 + 32 + 4
    assign lcnt_x100 = (DIV_N_W'(lcnt_reg) << 6) + (DIV_N_W'(lcnt_reg) << 5)
                     + (DIV_N_W'(lcnt_reg) << 2);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= 1'b0;
            local_reg      <= '0;
            remote_reg     <= '0;
            prev_local_reg <= '0;
            integ_reg      <= '0;
            corr_reg       <= '0;
            lcnt_reg       <= '0;
            prev_phase_reg <= '0;
            e_reg          <= '0;
            term_reg       <= '0;
            sum_reg        <= '0;
            nc_reg         <= '0;
            c_reg          <= '0;
            status_reg     <= STATUS_PRIMED;
            mul_start_reg  <= 1'b0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            div_start_reg  <= 1'b0;
            div_num_reg    <= '0;
            qual_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_PRIMED;
            out_corr_reg   <= '0;
            out_phase_reg  <= '0;
            out_qual_reg   <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            // the hand-over state decides the valid flag on its own
            if (out_ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        action_reg <= action;
                        local_reg  <= local_time;
                        remote_reg <= remote_time;
                        state_reg  <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    if (action_reg)
                    begin
                        prev_local_reg <= '0;
                        integ_reg      <= '0;
                        corr_reg       <= '0;
                        lcnt_reg       <= '0;
                        prev_phase_reg <= '0;
                        status_reg     <= STATUS_CLEARED;
                        state_reg      <= S_QSTART;
                    end
                    else if (prev_local_reg == '0)
                    begin
                        prev_local_reg <= local_reg;
                        status_reg     <= STATUS_PRIMED;
                        state_reg      <= S_QSTART;
                    end
                    else if (step_bad)
                    begin
                        status_reg <= STATUS_REJECTED;
                        state_reg  <= S_QSTART;
                    end
                    else
                    begin
                        e_reg         <= $signed(e_full);
                        mul_a_reg     <= $signed(e_full);
                        mul_b_reg     <= dt_full[MUL_B_W-1:0];
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_ED;
                    end
                end

                // integrate e*dt, update lock count, start proportional term
                S_MUL_ED:
                begin
                    if (mul_sts.done)
                    begin
                        integ_reg     <= integ_new;
                        lcnt_reg      <= lcnt_new;
                        mul_a_reg     <= e_reg;
                        mul_b_reg     <= MUL_B_W'(prop_gain_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_P;
                    end
                end

                S_MUL_P:
                begin
                    if (mul_sts.done)
                    begin
                        term_reg      <= mul_p >>> SH_P;
                        mul_a_reg     <= MUL_A_W'(integ_reg);
                        mul_b_reg     <= MUL_B_W'(int_gain_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_I;
                    end
                end

                S_MUL_I:
                begin
                    if (mul_sts.done)
                    begin
                        sum_reg   <= term_reg + (mul_p >>> SH_I);
                        state_reg <= S_SAT;
                    end
                end

                S_SAT:
                begin
                    nc_reg    <= nc_sat;
                    state_reg <= S_DIFF;
                end

                // smoothing: (new - corr) * 6554 >> 16
                S_DIFF:
                begin
                    mul_a_reg     <= MUL_A_W'(diff);
                    mul_b_reg     <= SMOOTH_NUM;
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MUL_S;
                end

                S_MUL_S:
                begin
                    if (mul_sts.done)
                    begin
                        c_reg     <= C_W'(corr_reg) + $signed(mul_p[SMOOTH_SH +: C_W]);
                        state_reg <= S_CLAMP;
                    end
                end

                S_CLAMP:
                begin
                    corr_reg       <= c_fin[CORR_W-1:0];
                    prev_local_reg <= local_reg;
                    prev_phase_reg <= e_reg;
                    status_reg     <= STATUS_UPDATED;
                    state_reg      <= S_QSTART;
                end

                S_QSTART:
                begin
                    div_num_reg   <= lcnt_x100;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_QUAL;
                end

                S_QUAL:
                begin
                    if (div_sts.done)
                    begin
                        if (lock_max_reg == '0)
                            qual_reg <= '0;
                        else if (div_q > DIV_N_W'(QUAL_FULL))
                            qual_reg <= QUAL_FULL;
                        else
                            qual_reg <= div_q[QUAL_W-1:0];
                        state_reg <= S_DONE;
                    end
                end

                // hand over once the result register is free
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_corr_reg   <= corr_reg;
                        out_phase_reg  <= prev_phase_reg;
                        out_qual_reg   <= qual_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign freq_correction = out_corr_reg;
    assign phase_error_ns  = out_phase_reg;
    assign lock_quality    = out_qual_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // integrator never leaves its saturation range
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= ACC_LIMIT) && (integ_reg >= -ACC_LIMIT))
        else $error("integrator out of range");

    // the shared multiplier is never restarted mid-pass
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |-> !mul_sts.busy)
        else $error("multiplier restarted while busy");

    // a new item only enters when both arithmetic units are quiet
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!mul_sts.busy && !div_sts.busy))
        else $error("item accepted while a unit is busy");

    // reported lock quality is a capped percentage
    a_qual_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lock_quality <= QUAL_FULL))
        else $error("lock quality above full scale");

    // a clear result carries zeroed loop outputs
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status_reg == STATUS_CLEARED))
            |-> ((freq_correction == '0) && (phase_error_ns == '0)
                 && (lock_quality == '0)))
        else $error("clear result not zero");

endmodule
`default_nettype wire
